// ----- hw/rtl/qpdt_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// qpdt_pkg
// Shared types and constants for the four-channel prescaled down timer.
// -----------------------------------------------------------------------------
package qpdt_pkg;

	localparam int MAX_CHANNELS = 4;
	localparam int DATA_BITS    = 32;
	localparam int CTRL_BITS    = 20;
	localparam int PRESC_BITS   = 8;
	localparam int NUM_PRESC    = 2;
	localparam int IRQ_PEND_LSB = 5;

	// operation codes
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// register map
	localparam logic [3:0] REG_PRESCALE  = 4'd0;
	localparam logic [3:0] REG_MUX       = 4'd1;
	localparam logic [3:0] REG_CONTROL   = 4'd2;
	localparam logic [3:0] REG_IRQ       = 4'd3;
	localparam logic [3:0] REG_RELOAD_LO = 4'd4;
	localparam logic [3:0] REG_RELOAD_HI = 4'd7;
	localparam logic [3:0] REG_COUNT_LO  = 4'd8;
	localparam logic [3:0] REG_COUNT_HI  = 4'd11;

	// control word fields, offsets from each channel's base
	localparam int BIT_START  = 0;
	localparam int BIT_UPDATE = 1;
	localparam int BIT_AUTO   = 3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [3:0]  irq_lines;
	} rsp_item_t;

	// per-channel strobes and enables from the register file
	typedef struct packed {
		logic tick;        // prescaled tick reaches this channel
		logic start;
		logic reload_en;
		logic load_reload; // write to the reload buffer
		logic load_count;  // manual update from the reload buffer
	} chan_ctl_t;

	function automatic int ctrl_base(input int ch);
		case (ch)
			0:       return 0;
			1:       return 8;
			2:       return 12;
			default: return 16;
		endcase
	endfunction

endpackage

// ----- hw/rtl/quad_prescaled_down_timer.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// quad_prescaled_down_timer
// Register file, prescalers and channel array of the four-channel timer.
// -----------------------------------------------------------------------------
// Each command (register read, register write or one input tick) is executed
// in the cycle it transfers and its response is registered, so one command per
// clock is sustained while responses are accepted. A two-entry output buffer
// lets one more command transfer while a response is stalled; cmd_ready drops
// only when both entries are full. Two 8-bit prescalers (channels 0-1 and 2-3)
// divide ticks by value+1; each started channel counts down per prescaled tick,
// flags pending at zero and optionally reloads. irq_lines in every response
// is pending AND enable after that command.
module quad_prescaled_down_timer #(
	parameter int CHANNELS   = 4,
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  qpdt_pkg::cmd_item_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output qpdt_pkg::rsp_item_t rsp
);
	import qpdt_pkg::*;

	localparam logic [MAX_CHANNELS-1:0] CH_MASK = MAX_CHANNELS'((1 << CHANNELS) - 1);

	logic                              xfer;
	logic                              is_write;
	logic                              is_tick;
	logic [15:0]                       prescale_q;
	logic [15:0]                       mux_q;
	logic [CTRL_BITS-1:0]              ctrl_q;
	logic [MAX_CHANNELS-1:0]           irq_en_q;
	logic [MAX_CHANNELS-1:0]           irq_pend_q;
	logic [MAX_CHANNELS-1:0]           irq_en_d;
	logic [MAX_CHANNELS-1:0]           irq_pend_d;
	logic [PRESC_BITS-1:0]             presc_cnt_q [NUM_PRESC];
	logic [NUM_PRESC-1:0]              fire;
	logic [MAX_CHANNELS-1:0]           expire;
	logic [DATA_BITS-1:0]              reload_rd [MAX_CHANNELS];
	logic [DATA_BITS-1:0]              count_rd  [MAX_CHANNELS];
	logic [DATA_BITS-1:0]              rd_data;
	rsp_item_t                         rsp_d;

	assign xfer     = cmd_valid && cmd_ready;
	assign is_write = xfer && (cmd.operation == OP_WRITE);
	assign is_tick  = xfer && (cmd.operation == OP_TICK);

	// prescalers
	for (genvar p = 0; p < NUM_PRESC; p++) begin : g_presc
		assign fire[p] = presc_cnt_q[p] >= prescale_q[PRESC_BITS*p +: PRESC_BITS];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				presc_cnt_q[p] <= '0;
			else if (is_tick)
				presc_cnt_q[p] <= fire[p] ? '0 : presc_cnt_q[p] + PRESC_BITS'(1);
		end
	end

	// channels
	for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_chan
		if (ch < CHANNELS) begin : g_on
			chan_ctl_t             ctl;
			logic [COUNT_BITS-1:0] count;
			logic [COUNT_BITS-1:0] reload;

			assign ctl.tick        = is_tick && fire[ch / 2];
			assign ctl.start       = ctrl_q[ctrl_base(ch) + BIT_START];
			assign ctl.reload_en   = ctrl_q[ctrl_base(ch) + BIT_AUTO];
			assign ctl.load_reload = is_write
				&& (cmd.reg_index == REG_RELOAD_LO + 4'(ch));
			// manual update looks at the newly written control word
			assign ctl.load_count  = is_write && (cmd.reg_index == REG_CONTROL)
				&& cmd.write_data[ctrl_base(ch) + BIT_UPDATE];

			qpdt_chan #(
				.COUNT_BITS(COUNT_BITS)
			) u_chan (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.wr_data (cmd.write_data[COUNT_BITS-1:0]),
				.count   (count),
				.reload  (reload),
				.expire  (expire[ch])
			);

			assign reload_rd[ch] = DATA_BITS'(reload);
			assign count_rd[ch]  = DATA_BITS'(count);
		end else begin : g_off
			assign expire[ch]    = 1'b0;
			assign reload_rd[ch] = '0;
			assign count_rd[ch]  = '0;
		end
	end

	// interrupt state
	always_comb begin
		irq_en_d   = irq_en_q;
		irq_pend_d = irq_pend_q | (expire & CH_MASK);
		if (is_write && (cmd.reg_index == REG_IRQ)) begin
			irq_en_d   = cmd.write_data[MAX_CHANNELS-1:0] & CH_MASK;
			irq_pend_d = irq_pend_q
				& ~cmd.write_data[IRQ_PEND_LSB +: MAX_CHANNELS] & CH_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			mux_q      <= '0;
			ctrl_q     <= '0;
			irq_en_q   <= '0;
			irq_pend_q <= '0;
		end else begin
			irq_en_q   <= irq_en_d;
			irq_pend_q <= irq_pend_d;
			if (is_write) begin
				case (cmd.reg_index)
					REG_PRESCALE: prescale_q <= cmd.write_data[15:0];
					REG_MUX:      mux_q      <= cmd.write_data[15:0];
					REG_CONTROL:  ctrl_q     <= cmd.write_data[CTRL_BITS-1:0];
					default:      ;
				endcase
			end
		end
	end

	// read mux
	always_comb begin
		rd_data = '0;
		if (cmd.operation == OP_READ) begin
			case (cmd.reg_index) inside
				REG_PRESCALE:                   rd_data = DATA_BITS'(prescale_q);
				REG_MUX:                        rd_data = DATA_BITS'(mux_q);
				REG_CONTROL:                    rd_data = DATA_BITS'(ctrl_q);
				REG_IRQ:                        rd_data = DATA_BITS'({irq_pend_q, 1'b0, irq_en_q});
				[REG_RELOAD_LO:REG_RELOAD_HI]:  rd_data = reload_rd[cmd.reg_index[1:0]];
				[REG_COUNT_LO:REG_COUNT_HI]:    rd_data = count_rd[cmd.reg_index[1:0]];
				default:                        rd_data = '0;
			endcase
		end
	end

	assign rsp_d.read_data = rd_data;
	assign rsp_d.irq_lines = irq_pend_d & irq_en_d;

	qpdt_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (xfer),
		.push_data (rsp_d),
		.can_push  (cmd_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- hw/rtl/qpdt_chan.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// qpdt_chan
// One down-counter channel with its reload buffer.
// -----------------------------------------------------------------------------
module qpdt_chan #(
	parameter int COUNT_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  qpdt_pkg::chan_ctl_t     ctl,
	input  logic [COUNT_BITS-1:0]   wr_data,
	output logic [COUNT_BITS-1:0]   count,
	output logic [COUNT_BITS-1:0]   reload,
	output logic                    expire
);
	import qpdt_pkg::*;

	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] reload_q;
	logic [COUNT_BITS-1:0] count_d;
	logic [COUNT_BITS-1:0] dec;

	assign dec = count_q - COUNT_BITS'(1);

	always_comb begin
		count_d = count_q;
		expire  = 1'b0;
		if (ctl.load_count) begin
			count_d = reload_q;
		end else if (ctl.tick && ctl.start) begin
			if (count_q != '0) begin
				count_d = dec;
				if (dec == '0) begin
					expire = 1'b1;
					if (ctl.reload_en)
						count_d = reload_q;
				end
			end else if (ctl.reload_en) begin
				// already at zero: reload without flagging
				count_d = reload_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			reload_q <= '0;
		end else begin
			count_q <= count_d;
			if (ctl.load_reload)
				reload_q <= wr_data;
		end
	end

	assign count  = count_q;
	assign reload = reload_q;

endmodule

// ----- hw/rtl/qpdt_outbuf.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// qpdt_outbuf
// Two-entry output register with skid slot, decouples response backpressure.
// -----------------------------------------------------------------------------
module qpdt_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qpdt_pkg::rsp_item_t push_data,
	output logic                can_push,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output qpdt_pkg::rsp_item_t rsp
);
	import qpdt_pkg::*;

	rsp_item_t main_q;
	rsp_item_t skid_q;
	logic      main_vld_q;
	logic      skid_vld_q;
	logic      pop;

	assign pop      = main_vld_q && rsp_ready;
	assign can_push = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop)
				skid_vld_q <= 1'b0;
		end else if (push) begin
			if (!main_vld_q || pop)
				main_vld_q <= 1'b1;
			else
				skid_vld_q <= 1'b1;
		end else if (pop) begin
			main_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (!main_vld_q || pop)
				main_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

	assign rsp_valid = main_vld_q;
	assign rsp       = main_q;

endmodule

// ----- tb/quad_prescaled_down_timer_tb.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// quad_prescaled_down_timer_tb
// Self-checking bench for the four-channel prescaled down timer.
// -----------------------------------------------------------------------------
// Register reads, writes and ticks go in over the command channel. A shadow copy
// of the timer state, updated at each command transfer, predicts the response.
// Each response is checked in order against that prediction. Both channels idle
// in random bursts, except in the final back-to-back stretch.
module quad_prescaled_down_timer_tb;

	import qpdt_pkg::*;

	localparam logic [1:0] OP_NONE      = 2'd3;
	localparam logic [3:0] REG_UNUSED   = 4'd12;
	localparam logic [3:0] REG_LAST     = 4'd15;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 10;
	localparam int         REPORT_MAX   = 10;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_item_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	// shadow of the timer state
	logic [15:0] sh_presc;
	logic [15:0] sh_mux;
	logic [CTRL_BITS-1:0] sh_ctrl;
	logic [3:0]  sh_irq_en;
	logic [3:0]  sh_pend;
	logic [31:0] sh_reload [MAX_CHANNELS];
	logic [31:0] sh_count  [MAX_CHANNELS];
	logic [7:0]  sh_pcnt   [NUM_PRESC];

	rsp_item_t   timer_rsp_q[$];
	rsp_item_t   oldest_rsp;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned stall_left     = 0;
	bit          idle_enabled   = 1'b1;
	bit          cmd_drv        = 1'b0;

	quad_prescaled_down_timer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	function automatic int chan_base(input int ch);
		return (ch == 0) ? 0 : 4 * ch + 4;
	endfunction

	function automatic cmd_item_t mk_cmd(input logic [1:0] op, input logic [3:0] idx,
	                                     input logic [31:0] data);
		cmd_item_t c;
		c.operation  = op;
		c.reg_index  = idx;
		c.write_data = data;
		return c;
	endfunction

	function automatic logic [31:0] shadow_read(input logic [3:0] idx);
		if (idx == REG_PRESCALE)
			return {16'h0, sh_presc};
		if (idx == REG_MUX)
			return {16'h0, sh_mux};
		if (idx == REG_CONTROL)
			return 32'(sh_ctrl);
		if (idx == REG_IRQ)
			return 32'(sh_irq_en) | (32'(sh_pend) << IRQ_PEND_LSB);
		if (idx >= REG_RELOAD_LO && idx <= REG_RELOAD_HI)
			return sh_reload[idx - REG_RELOAD_LO];
		if (idx >= REG_COUNT_LO && idx <= REG_COUNT_HI)
			return sh_count[idx - REG_COUNT_LO];
		return 32'h0;
	endfunction

	task automatic shadow_write(input logic [3:0] idx, input logic [31:0] data);
		int ch;
		if (idx == REG_PRESCALE) begin
			sh_presc = data[15:0];
		end else if (idx == REG_MUX) begin
			sh_mux = data[15:0];
		end else if (idx == REG_CONTROL) begin
			sh_ctrl = data[CTRL_BITS-1:0];
			for (ch = 0; ch < MAX_CHANNELS; ch++)
				if (sh_ctrl[chan_base(ch) + BIT_UPDATE])
					sh_count[ch] = sh_reload[ch];
		end else if (idx == REG_IRQ) begin
			sh_irq_en = data[3:0];
			sh_pend   = sh_pend & ~data[IRQ_PEND_LSB +: 4];
		end else if (idx >= REG_RELOAD_LO && idx <= REG_RELOAD_HI) begin
			sh_reload[idx - REG_RELOAD_LO] = data;
		end
	endtask

	task automatic shadow_channel_tick(input int ch);
		int b;
		b = chan_base(ch);
		if (!sh_ctrl[b + BIT_START])
			return;
		if (sh_count[ch] != 0) begin
			sh_count[ch] = sh_count[ch] - 1;
			if (sh_count[ch] == 0) begin
				sh_pend[ch] = 1'b1;
				if (sh_ctrl[b + BIT_AUTO])
					sh_count[ch] = sh_reload[ch];
			end
		end else if (sh_ctrl[b + BIT_AUTO]) begin
			// started at zero with auto-reload: reload, no pending flag
			sh_count[ch] = sh_reload[ch];
		end
	endtask

	task automatic predict_timer(input cmd_item_t c, output rsp_item_t r);
		int p;
		r = '0;
		case (c.operation)
			OP_READ: begin
				r.read_data = shadow_read(c.reg_index);
			end
			OP_WRITE: begin
				shadow_write(c.reg_index, c.write_data);
			end
			OP_TICK: begin
				for (p = 0; p < NUM_PRESC; p++) begin
					if (sh_pcnt[p] >= sh_presc[8 * p +: 8]) begin
						sh_pcnt[p] = '0;
						shadow_channel_tick(2 * p);
						shadow_channel_tick(2 * p + 1);
					end else begin
						sh_pcnt[p] = sh_pcnt[p] + 8'd1;
					end
				end
			end
			default: begin
			end
		endcase
		r.irq_lines = sh_pend & sh_irq_en;
	endtask

	task automatic shadow_reset();
		int i;
		sh_presc  = '0;
		sh_mux    = '0;
		sh_ctrl   = '0;
		sh_irq_en = '0;
		sh_pend   = '0;
		for (i = 0; i < MAX_CHANNELS; i++) begin
			sh_reload[i] = '0;
			sh_count[i]  = '0;
		end
		for (i = 0; i < NUM_PRESC; i++)
			sh_pcnt[i] = '0;
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t ns: %s", $time, what);
	endtask

	// One command transfer; valid stays up afterward so the next call can
	// follow in the same cycle without a bubble.
	task automatic send_cmd(input cmd_item_t c);
		int unsigned gap;
		rsp_item_t   r;
		if (idle_enabled && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			if (cmd_drv) begin
				cmd_valid <= 1'b0;
				cmd_drv = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		cmd_drv = 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		predict_timer(c, r);
		timer_rsp_q.push_back(r);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
		send_cmd(mk_cmd(OP_WRITE, idx, data));
	endtask

	task automatic read_reg(input logic [3:0] idx);
		send_cmd(mk_cmd(OP_READ, idx, $urandom));
	endtask

	task automatic send_tick();
		send_cmd(mk_cmd(OP_TICK, 4'($urandom), $urandom));
	endtask

	function automatic logic [7:0] pick_divider();
		return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
	endfunction

	// Program prescalers, reloads, interrupts and control, then let it run.
	task automatic run_timer_sequence();
		logic [31:0] data;
		int          ch;
		int          b;
		int unsigned n;
		int unsigned sel;
		data = $urandom;
		data[7:0]  = pick_divider();
		data[15:8] = pick_divider();
		write_reg(REG_PRESCALE, data);
		for (ch = 0; ch < MAX_CHANNELS; ch++)
			write_reg(REG_RELOAD_LO + 4'(ch), ($urandom_range(0, 9) == 0) ?
			          $urandom : 32'($urandom_range(0, 6)));
		data = $urandom;
		data[IRQ_PEND_LSB +: 4] = 4'hF;
		write_reg(REG_IRQ, data);
		data = $urandom;
		for (ch = 0; ch < MAX_CHANNELS; ch++) begin
			b = chan_base(ch);
			data[b + BIT_START]  = ($urandom_range(0, 3) != 0);
			data[b + BIT_UPDATE] = $urandom_range(0, 1);
			data[b + BIT_AUTO]   = $urandom_range(0, 1);
		end
		write_reg(REG_CONTROL, data);
		n = $urandom_range(30, 60);
		repeat (n) begin
			sel = $urandom_range(0, 9);
			if (sel < 7)
				send_tick();
			else if (sel < 9)
				read_reg(4'($urandom_range(0, 11)));
			else
				write_reg(REG_IRQ, $urandom);
		end
	endtask

	task automatic test_register_map();
		write_reg(REG_PRESCALE, 32'hFFFF_FFFF);
		read_reg(REG_PRESCALE);
		write_reg(REG_PRESCALE, 32'h0);
		write_reg(REG_MUX, 32'hFFFF_FFFF);
		read_reg(REG_MUX);
		write_reg(REG_RELOAD_LO, 32'hFFFF_FFFF);
		write_reg(REG_RELOAD_LO + 4'd1, 32'd2);
		write_reg(REG_RELOAD_LO + 4'd2, 32'd1);
		write_reg(REG_RELOAD_HI, 32'd0);
		read_reg(REG_RELOAD_LO);
		// count registers and unused indices ignore writes
		write_reg(REG_COUNT_LO, 32'h1234_5678);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		read_reg(REG_LAST);
		write_reg(REG_IRQ, 32'hFFFF_FFFF);
		// manual update on every channel, bits above the control width dropped
		write_reg(REG_CONTROL, 32'hFFFF_FFFF);
		read_reg(REG_CONTROL);
		read_reg(REG_COUNT_LO);
	endtask

	task automatic test_channel_expiry();
		logic [31:0] ctl;
		ctl = '0;
		ctl[chan_base(0) + BIT_START] = 1'b1;
		ctl[chan_base(1) + BIT_START] = 1'b1;
		ctl[chan_base(1) + BIT_AUTO]  = 1'b1;
		ctl[chan_base(2) + BIT_START] = 1'b1;
		ctl[chan_base(3) + BIT_START] = 1'b1;
		ctl[chan_base(3) + BIT_AUTO]  = 1'b1;
		write_reg(REG_CONTROL, ctl);
		repeat (4) send_tick();
		read_reg(REG_IRQ);
		send_cmd(mk_cmd(OP_NONE, REG_IRQ, 32'hFFFF_FFFF));
		write_reg(REG_IRQ, 32'h0000_01EF);
		read_reg(REG_COUNT_LO + 4'd1);
	endtask

	task automatic test_timer_sequences();
		repeat (12) run_timer_sequence();
	endtask

	task automatic test_random_mix();
		cmd_item_t   c;
		int unsigned sel;
		repeat (350) begin
			sel = $urandom_range(0, 19);
			c = mk_cmd(OP_TICK, 4'($urandom), $urandom);
			if (sel >= 9 && sel < 14)
				c.operation = OP_READ;
			else if (sel >= 14 && sel < 19)
				c.operation = OP_WRITE;
			else if (sel == 19)
				c.operation = OP_NONE;
			if (c.operation == OP_WRITE && $urandom_range(0, 3) != 0) begin
				if (c.reg_index == REG_PRESCALE) begin
					c.write_data[7:0]  = pick_divider();
					c.write_data[15:8] = pick_divider();
				end else if (c.reg_index >= REG_RELOAD_LO && c.reg_index <= REG_RELOAD_HI) begin
					c.write_data = 32'($urandom_range(0, 8));
				end
			end
			send_cmd(c);
		end
	endtask

	task automatic test_back_to_back();
		idle_enabled = 1'b0;
		repeat (2) run_timer_sequence();
	endtask

	// response side: random stalls and in-order check
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ready  <= 1'b0;
		end else if (arst_n && idle_enabled && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 11);
			rsp_ready  <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (timer_rsp_q.size() == 0) begin
				report_mismatch($sformatf("response with none expected: read_data %h irq %h",
				                          rsp.read_data, rsp.irq_lines));
			end else begin
				oldest_rsp = timer_rsp_q.pop_front();
				if (rsp.read_data !== oldest_rsp.read_data ||
				    rsp.irq_lines !== oldest_rsp.irq_lines)
					report_mismatch($sformatf(
						"read_data exp %h got %h, irq_lines exp %h got %h",
						oldest_rsp.read_data, rsp.read_data,
						oldest_rsp.irq_lines, rsp.irq_lines));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		shadow_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_map();
		test_channel_expiry();
		test_timer_sequences();
		test_random_mix();
		test_back_to_back();

		cmd_valid <= 1'b0;
		cmd_drv = 1'b0;
		while (timer_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/qpdt_pkg.sv
hw/rtl/qpdt_chan.sv
hw/rtl/qpdt_outbuf.sv
hw/rtl/quad_prescaled_down_timer.sv
tb/quad_prescaled_down_timer_tb.sv
